### design/crs_pkg.sv
package crs_pkg;

	localparam int MAX_PAIRS_DEF = 16;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_COPR = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_ZERO_MOD = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PLO,
		OP_PHI,
		OP_PUPD,
		OP_RD,
		OP_DMI,
		OP_SMI,
		OP_DA,
		OP_SA,
		OP_DQ,
		OP_SQ,
		OP_QMUL,
		OP_EUPD,
		OP_FIX,
		OP_DR,
		OP_SR,
		OP_RMUL,
		OP_DT,
		OP_ST,
		OP_TLO,
		OP_THI,
		OP_ACC,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last;
		logic zero;
		logic ovf;
		logic idx_end;
		logic b_zero;
		logic gcd_one;
	} stat_t;

endpackage

### design/chinese_remainder_solver.sv
// Chinese remainder solver. Feed (modulus, remainder) pairs one beat at a time
// with start while busy is low; the beat with last high closes the set and
// starts the solve. Each loading beat keeps the block busy while the 62 x 32
// product update runs as two 32 x 32 partial products on the one shared
// multiplier. The solve then works through the stored pairs one at a time;
// per pair it runs three 64-bit divisions and one 32-bit division, plus one
// 32-bit division per extended Euclid step, all on the single bit-per-cycle
// divider. Exactly one result beat per set: done is high for one cycle with
// solution and status, and the receiver cannot stall it, so capture it on
// that cycle. Status 0 is ok, 1 moduli not coprime, 2 product above 62 bits
// or too many pairs, 3 zero modulus; solution is zero on error.
module chinese_remainder_solver #(
	parameter int MAX_PAIRS = crs_pkg::MAX_PAIRS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] modulus,
	input  logic [31:0] remainder,
	input  logic        last,
	output logic        done,
	output logic [61:0] solution,
	output logic [1:0]  status
);
	import crs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequence the load and solve steps
	crs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	// hold the stores, the running product and the shared arithmetic
	crs_datapath #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.modulus  (modulus),
		.remainder(remainder),
		.last     (last),
		.done     (done),
		.solution (solution),
		.status   (status)
	);
endmodule

### design/crs_div.sv
module crs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        narrow,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quo,
	output logic [31:0] rem
);
	logic [63:0] dvd_q;
	logic [31:0] rr_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] sh;
	logic        fit;
	logic [32:0] diff;

	assign sh   = {rr_q, dvd_q[63]};
	assign fit  = sh >= {1'b0, dsr_q};
	assign diff = sh - {1'b0, dsr_q};

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= narrow ? 7'd32 : 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rr_q  <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[62:0], fit};
			rr_q  <= fit ? diff[31:0] : sh[31:0];
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;
	assign rem  = rr_q;
endmodule

### design/crs_datapath.sv
module crs_datapath #(
	parameter int MAX_PAIRS = crs_pkg::MAX_PAIRS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  crs_pkg::cmd_t cmd,
	output crs_pkg::stat_t stat,
	input  logic [31:0]   modulus,
	input  logic [31:0]   remainder,
	input  logic          last,
	output logic          done,
	output logic [61:0]   solution,
	output logic [1:0]    status
);
	import crs_pkg::*;

	localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAIRS);

	logic [31:0] mod_mem [MAX_PAIRS];
	logic [31:0] rem_mem [MAX_PAIRS];

	logic [CW-1:0] cnt_q, idx_q;
	logic [61:0]   prod_q, mi_q, sum_q, sol_q;
	logic          ovf_q, zero_q, st_q, last_q, done_q;
	logic [1:0]    status_q;
	logic [31:0]   in_m_q, rd_m_q, rd_r_q;
	logic [31:0]   a_q, b_q, q_q, nr_q, t_q, inv_q;
	logic signed [32:0] os_q, s_q;
	logic [63:0]   mul_q, lo_q;

	logic [31:0]   ma, mb, s_mag;
	logic [63:0]   mprod;
	logic [94:0]   pfull;
	logic [61:0]   term;
	logic [62:0]   acc;
	logic signed [33:0] qs, ns;
	logic [32:0]   fixed;
	logic          div_start, div_narrow, div_done;
	logic [63:0]   div_dvd, div_quo;
	logic [31:0]   div_dsr, div_rem;

	assign s_mag = s_q[32] ? 32'(-s_q) : s_q[31:0];

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_PLO: begin ma = {1'b0, prod_q[30:0]}; mb = in_m_q; end
			OP_PHI: begin ma = {1'b0, prod_q[61:31]}; mb = in_m_q; end
			OP_QMUL: begin ma = q_q; mb = s_mag; end
			OP_RMUL: begin ma = t_q; mb = inv_q; end
			OP_TLO: begin ma = t_q; mb = {1'b0, mi_q[30:0]}; end
			OP_THI: begin ma = t_q; mb = {1'b0, mi_q[61:31]}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign mprod = ma * mb;

	assign pfull = {mul_q, 31'b0} + {31'b0, lo_q};
	assign term  = {mul_q[30:0], 31'b0} + lo_q[61:0];
	assign acc   = {1'b0, sum_q} + {1'b0, term};
	assign qs    = s_q[32] ? -$signed({1'b0, mul_q[32:0]}) : $signed({1'b0, mul_q[32:0]});
	assign ns    = 34'(os_q) - qs;
	assign fixed = os_q[32] ? 33'(os_q) + {1'b0, rd_m_q} : 33'(os_q);

	always_comb begin
		div_start  = 1'b0;
		div_narrow = 1'b0;
		div_dvd    = '0;
		div_dsr    = rd_m_q;
		case (cmd.op)
			OP_DMI: begin div_start = 1'b1; div_dvd = {2'b0, prod_q}; end
			OP_DA: begin div_start = 1'b1; div_dvd = {2'b0, mi_q}; end
			OP_DQ: begin
				div_start = 1'b1; div_narrow = 1'b1;
				div_dvd = {a_q, 32'b0}; div_dsr = b_q;
			end
			OP_DR: begin
				div_start = 1'b1; div_narrow = 1'b1;
				div_dvd = {rd_r_q, 32'b0};
			end
			OP_DT: begin div_start = 1'b1; div_dvd = mul_q; end
			default: begin div_start = 1'b0; end
		endcase
	end

	crs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.narrow  (div_narrow),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// pair stores
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && cnt_q < MAX_CNT) begin
			mod_mem[cnt_q[AW-1:0]] <= modulus;
			rem_mem[cnt_q[AW-1:0]] <= remainder;
		end
		if (cmd.op == OP_RD) begin
			rd_m_q <= mod_mem[idx_q[AW-1:0]];
			rd_r_q <= rem_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			prod_q   <= 62'd1;
			ovf_q    <= 1'b0;
			zero_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					if (cnt_q < MAX_CNT) cnt_q <= cnt_q + CW'(1);
					else ovf_q <= 1'b1;
					if (modulus == '0) zero_q <= 1'b1;
				end
				OP_PUPD: begin
					if (st_q && in_m_q != '0 && !ovf_q) begin
						if (|pfull[94:62]) ovf_q <= 1'b1;
						else prod_q <= pfull[61:0];
					end
				end
				OP_OUT: begin
					done_q   <= 1'b1;
					status_q <= cmd.code;
					cnt_q    <= '0;
					prod_q   <= 62'd1;
					ovf_q    <= 1'b0;
					zero_q   <= 1'b0;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// working registers of the solve
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				in_m_q <= modulus;
				last_q <= last;
				st_q   <= cnt_q < MAX_CNT;
			end
			OP_PLO, OP_TLO: lo_q <= mprod;
			OP_PHI, OP_THI, OP_QMUL, OP_RMUL: mul_q <= mprod;
			OP_PUPD: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			OP_SMI: mi_q <= div_quo[61:0];
			OP_SA: begin
				a_q  <= div_rem;
				b_q  <= rd_m_q;
				os_q <= 33'sd1;
				s_q  <= 33'sd0;
			end
			OP_SQ: begin
				q_q  <= div_quo[31:0];
				nr_q <= div_rem;
			end
			OP_EUPD: begin
				os_q <= s_q;
				s_q  <= ns[32:0];
				a_q  <= b_q;
				b_q  <= nr_q;
			end
			OP_FIX: inv_q <= fixed[31:0];
			OP_SR, OP_ST: t_q <= div_rem;
			OP_ACC: begin
				sum_q <= (acc >= {1'b0, prod_q}) ? 62'(acc - {1'b0, prod_q}) : acc[61:0];
				idx_q <= idx_q + CW'(1);
			end
			OP_OUT: sol_q <= (cmd.code == ST_OK) ? sum_q : '0;
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign stat.div_done = div_done;
	assign stat.last     = last_q;
	assign stat.zero     = zero_q;
	assign stat.ovf      = ovf_q;
	assign stat.idx_end  = idx_q == cnt_q;
	assign stat.b_zero   = b_q == '0;
	assign stat.gcd_one  = a_q == 32'd1;

	assign done     = done_q;
	assign solution = sol_q;
	assign status   = status_q;
endmodule

### design/crs_ctrl.sv
module crs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  crs_pkg::stat_t stat,
	output crs_pkg::cmd_t  cmd
);
	import crs_pkg::*;

	typedef enum logic [22:0] {
		S_IDLE  = 23'd1 << 0,
		S_PLO   = 23'd1 << 1,
		S_PHI   = 23'd1 << 2,
		S_PUPD  = 23'd1 << 3,
		S_CHECK = 23'd1 << 4,
		S_RD    = 23'd1 << 5,
		S_DMI   = 23'd1 << 6,
		S_WMI   = 23'd1 << 7,
		S_DA    = 23'd1 << 8,
		S_WA    = 23'd1 << 9,
		S_ETEST = 23'd1 << 10,
		S_DQ    = 23'd1 << 11,
		S_WQ    = 23'd1 << 12,
		S_QMUL  = 23'd1 << 13,
		S_EUPD  = 23'd1 << 14,
		S_DR    = 23'd1 << 15,
		S_WR    = 23'd1 << 16,
		S_RMUL  = 23'd1 << 17,
		S_DT    = 23'd1 << 18,
		S_WT    = 23'd1 << 19,
		S_TMUL  = 23'd1 << 20,
		S_THI   = 23'd1 << 21,
		S_ACC   = 23'd1 << 22
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_OK;
		case (state_q)
			S_IDLE: if (start) begin cmd.op = OP_LOAD; state_d = S_PLO; end
			S_PLO: begin cmd.op = OP_PLO; state_d = S_PHI; end
			S_PHI: begin cmd.op = OP_PHI; state_d = S_PUPD; end
			S_PUPD: begin
				cmd.op  = OP_PUPD;
				state_d = stat.last ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				if (stat.zero || stat.ovf || stat.idx_end) begin
					cmd.op   = OP_OUT;
					cmd.code = stat.zero ? ST_ZERO_MOD : stat.ovf ? ST_OVERFLOW : ST_OK;
					state_d  = S_IDLE;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin cmd.op = OP_RD; state_d = S_DMI; end
			S_DMI: begin cmd.op = OP_DMI; state_d = S_WMI; end
			S_WMI: if (stat.div_done) begin cmd.op = OP_SMI; state_d = S_DA; end
			S_DA: begin cmd.op = OP_DA; state_d = S_WA; end
			S_WA: if (stat.div_done) begin cmd.op = OP_SA; state_d = S_ETEST; end
			S_ETEST: begin
				if (!stat.b_zero) begin
					state_d = S_DQ;
				end else if (stat.gcd_one) begin
					cmd.op  = OP_FIX;
					state_d = S_DR;
				end else begin
					cmd.op   = OP_OUT;
					cmd.code = ST_NOT_COPR;
					state_d  = S_IDLE;
				end
			end
			S_DQ: begin cmd.op = OP_DQ; state_d = S_WQ; end
			S_WQ: if (stat.div_done) begin cmd.op = OP_SQ; state_d = S_QMUL; end
			S_QMUL: begin cmd.op = OP_QMUL; state_d = S_EUPD; end
			S_EUPD: begin cmd.op = OP_EUPD; state_d = S_ETEST; end
			S_DR: begin cmd.op = OP_DR; state_d = S_WR; end
			S_WR: if (stat.div_done) begin cmd.op = OP_SR; state_d = S_RMUL; end
			S_RMUL: begin cmd.op = OP_RMUL; state_d = S_DT; end
			S_DT: begin cmd.op = OP_DT; state_d = S_WT; end
			S_WT: if (stat.div_done) begin cmd.op = OP_ST; state_d = S_TMUL; end
			S_TMUL: begin cmd.op = OP_TLO; state_d = S_THI; end
			S_THI: begin cmd.op = OP_THI; state_d = S_ACC; end
			// the accumulate runs in the cycle after the high partial product
			S_ACC: begin cmd.op = OP_ACC; state_d = S_CHECK; end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
endmodule

### design/crs_checker.sv
module crs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [61:0] solution,
	input logic [1:0]  status
);
	import crs_pkg::*;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> solution == '0)
		else $error("error result carries a nonzero solution");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_no_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result right after an accepted beat");
endmodule

bind chinese_remainder_solver crs_checker u_crs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.solution(solution),
	.status  (status)
);
